### hdl/cic_charge_deposit_defines.svh
// ----------------------------------------------------------------------------
// cic_charge_deposit_defines.svh
// assertion macros used by the charge deposit controller
// ----------------------------------------------------------------------------
`ifndef CIC_CHARGE_DEPOSIT_DEFINES_SVH
`define CIC_CHARGE_DEPOSIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccd assertion failed");

// next-cycle implication, checked outside reset
`define CCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccd assertion failed");

`endif

### hdl/ccd_pkg.sv
// ----------------------------------------------------------------------------
// ccd_pkg
// types and constants of the cloud-in-cell charge deposit block
// ----------------------------------------------------------------------------
package ccd_pkg;

    // input transaction
    typedef struct packed {
        logic              cmd;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] charge;
        logic        [5:0]  cell_x;
        logic        [5:0]  cell_y;
    } t_in;

    // result transaction
    typedef struct packed {
        logic signed [63:0] density;
        logic               out_of_range;
    } t_out;

    // command codes
    localparam logic CMD_DEPOSIT = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    // configuration register indexes
    localparam int          CFG_IDX_W         = 3;
    localparam logic [2:0]  CFG_ORIGIN_X      = 3'd0;
    localparam logic [2:0]  CFG_ORIGIN_Y      = 3'd1;
    localparam logic [2:0]  CFG_INV_SPACING_X = 3'd2;
    localparam logic [2:0]  CFG_INV_SPACING_Y = 3'd3;
    localparam logic [2:0]  CFG_INV_CELL_AREA = 3'd4;

    // 1.0 in Q16.16
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic mul_x;
        logic mul_y;
        logic rnd_y;
        logic wgt;
        logic mul_c;
        logic acc;
        logic rd_addr;
        logic rd_abs;
        logic rd_lo;
        logic rd_hi;
        logic rd_fin;
        logic clr;
        logic load_out;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic last_corner;
        logic is_read;
        logic rd_inb;
    } t_sts;

endpackage

### hdl/ccd_dp.sv
// ----------------------------------------------------------------------------
// ccd_dp
// datapath: configuration registers, shared multiplier, weights, grid memory
// ----------------------------------------------------------------------------
module ccd_dp #(
    parameter int GRID_X = 64,
    parameter int GRID_Y = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ccd_pkg::t_in                    i_in_data,
    input  logic                            i_cfg_valid,
    input  logic [ccd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                     i_cfg_data,
    input  ccd_pkg::t_cmd                   i_cmd,
    output ccd_pkg::t_sts                   o_sts,
    output ccd_pkg::t_out                   o_out_data
);

    localparam int XW    = $clog2(GRID_X);
    localparam int YW    = $clog2(GRID_Y);
    localparam int DEPTH = GRID_X * GRID_Y;
    localparam int AW    = $clog2(DEPTH);

    // round a grid product toward minus infinity to signed Q.16
    function automatic logic signed [49:0] round_g(input logic [63:0] p, input logic neg);
        logic [64:0] s;
        logic [49:0] m;
        s = {1'b0, p} + 65'h0FFFF;
        if (neg) begin
            m = {1'b0, s[64:16]};
            return -$signed(m);
        end
        m = {2'b00, p[63:16]};
        return $signed(m);
    endfunction

    // configuration registers
    logic [31:0] r_org_x, r_org_y, r_isp_x, r_isp_y, r_inv_area;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x    <= '0;
            r_org_y    <= '0;
            r_isp_x    <= ccd_pkg::ONE_Q16;
            r_isp_y    <= ccd_pkg::ONE_Q16;
            r_inv_area <= ccd_pkg::ONE_Q16;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ccd_pkg::CFG_ORIGIN_X:      r_org_x    <= i_cfg_data;
                ccd_pkg::CFG_ORIGIN_Y:      r_org_y    <= i_cfg_data;
                ccd_pkg::CFG_INV_SPACING_X: r_isp_x    <= i_cfg_data;
                ccd_pkg::CFG_INV_SPACING_Y: r_isp_y    <= i_cfg_data;
                ccd_pkg::CFG_INV_CELL_AREA: r_inv_area <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // working registers
    ccd_pkg::t_in        r_in;
    logic [63:0]         r_prod, r_lo, r_mag, r_rdata, r_c;
    logic                r_neg, r_inb, r_flag;
    logic signed [49:0]  r_gx, r_gy;
    logic [32:0]         r_w;
    logic [AW-1:0]       r_addr, r_clr;
    logic [1:0]          r_k;
    logic signed [63:0]  r_dens;
    ccd_pkg::t_out       r_out;
    logic [63:0]         mem [DEPTH];

    // position relative to the origin
    logic signed [32:0] w_dx, w_dy;
    logic [32:0]        w_ax, w_ay;
    assign w_dx = {r_in.pos_x[31], r_in.pos_x} - {r_org_x[31], r_org_x};
    assign w_dy = {r_in.pos_y[31], r_in.pos_y} - {r_org_y[31], r_org_y};
    assign w_ax = w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
    assign w_ay = w_dy[32] ? 33'(-w_dy) : 33'(w_dy);

    // shared unsigned multiplier
    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] w_prod;
    always_comb begin
        mul_a = w_ax;
        mul_b = r_isp_x;
        if (i_cmd.mul_y) begin
            mul_a = w_ay;
            mul_b = r_isp_y;
        end else if (i_cmd.rd_lo) begin
            mul_a = {1'b0, r_mag[31:0]};
            mul_b = r_inv_area;
        end else if (i_cmd.rd_hi) begin
            mul_a = {1'b0, r_mag[63:32]};
            mul_b = r_inv_area;
        end
    end
    assign w_prod = {32'b0, mul_a} * {33'b0, mul_b};

    // corner weights and address
    logic               a_sel, b_sel;
    logic [16:0]        wx, wy;
    logic [33:0]        w_w;
    logic signed [34:0] cx, cy;
    logic               inb_c, wnz;
    logic [AW-1:0]      corner_addr, cell_addr, addr_d;
    logic               cell_inb;
    assign a_sel = r_k[0];
    assign b_sel = r_k[1];
    assign wx = a_sel ? {1'b0, r_gx[15:0]} : 17'h10000 - {1'b0, r_gx[15:0]};
    assign wy = b_sel ? {1'b0, r_gy[15:0]} : 17'h10000 - {1'b0, r_gy[15:0]};
    assign w_w = wx * wy;
    assign wnz = (wx != '0) && (wy != '0);
    assign cx = {r_gx[49], r_gx[49:16]} + 35'(a_sel);
    assign cy = {r_gy[49], r_gy[49:16]} + 35'(b_sel);
    assign inb_c = (cx >= 0) && (cx < $signed(35'(GRID_X)))
                && (cy >= 0) && (cy < $signed(35'(GRID_Y)));
    assign corner_addr = AW'(AW'(cy[YW-1:0]) * AW'(GRID_X)) + AW'(cx[XW-1:0]);
    assign cell_inb = ({26'b0, r_in.cell_x} < 32'(GRID_X))
                   && ({26'b0, r_in.cell_y} < 32'(GRID_Y));
    assign cell_addr = AW'(AW'(YW'(r_in.cell_y)) * AW'(GRID_X)) + AW'(XW'(r_in.cell_x));
    assign addr_d = r_in.cmd ? cell_addr : corner_addr;

    // charge times weight
    logic signed [65:0] w_c;
    assign w_c = $signed(r_in.charge) * $signed({1'b0, r_w});

    // read scaling and saturation
    localparam logic [63:0] SMAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] SMIN = {1'b1, 63'b0};
    logic [63:0] sat_mag, sat_res;
    always_comb begin
        sat_mag = (r_prod << 16) + (r_lo >> 16);
        if (r_prod[63:47] != '0) begin
            sat_res = r_neg ? SMIN : SMAX;
        end else if (r_neg) begin
            sat_res = (sat_mag > SMIN) ? SMIN : -sat_mag;
        end else begin
            sat_res = sat_mag[63] ? SMAX : sat_mag;
        end
    end

    // memory write port
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [63:0]   mem_wd;
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_addr;
        mem_wd = '0;
        if (i_cmd.clr) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
        end else if (i_cmd.acc) begin
            mem_we = r_inb;
            mem_wd = r_rdata + {{16{r_c[63]}}, r_c[63:16]};
        end else if (i_cmd.rd_abs) begin
            mem_we = 1'b1;
        end
    end

    // grid memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[addr_d];
    end

    // control-like registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_k   <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.load_in) begin
                r_k <= '0;
            end else if (i_cmd.acc) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in   <= i_in_data;
            r_flag <= 1'b0;
            r_dens <= '0;
        end
        if (i_cmd.mul_x) begin
            r_prod <= w_prod[63:0];
            r_neg  <= w_dx[32];
        end
        if (i_cmd.mul_y) begin
            r_gx   <= round_g(r_prod, r_neg);
            r_prod <= w_prod[63:0];
            r_neg  <= w_dy[32];
        end
        if (i_cmd.rnd_y) begin
            r_gy <= round_g(r_prod, r_neg);
        end
        if (i_cmd.wgt) begin
            r_w    <= w_w[32:0];
            r_inb  <= inb_c;
            r_addr <= addr_d;
            if (!inb_c && wnz) begin
                r_flag <= 1'b1;
            end
        end
        if (i_cmd.mul_c) begin
            r_c <= w_c[63:0];
        end
        if (i_cmd.rd_addr) begin
            r_addr <= addr_d;
            if (!cell_inb) begin
                r_flag <= 1'b1;
            end
        end
        if (i_cmd.rd_abs) begin
            r_neg <= r_rdata[63];
            r_mag <= r_rdata[63] ? -r_rdata : r_rdata;
        end
        if (i_cmd.rd_lo) begin
            r_prod <= w_prod[63:0];
        end
        if (i_cmd.rd_hi) begin
            r_lo   <= r_prod + (r_neg ? 64'h0FFFF : 64'h0);
            r_prod <= w_prod[63:0];
        end
        if (i_cmd.rd_fin) begin
            r_dens <= $signed(sat_res);
        end
        if (i_cmd.load_out) begin
            r_out.density      <= r_dens;
            r_out.out_of_range <= r_flag;
        end
    end

    // status
    assign o_sts.clr_last    = (r_clr == AW'(DEPTH - 1));
    assign o_sts.last_corner = (r_k == 2'd3);
    assign o_sts.is_read     = (r_in.cmd == ccd_pkg::CMD_READ);
    assign o_sts.rd_inb      = cell_inb;
    assign o_out_data        = r_out;

endmodule

### hdl/ccd_ctrl.sv
// ----------------------------------------------------------------------------
// ccd_ctrl
// sequencer for deposit and read transactions, grid clearing and output slot
// ----------------------------------------------------------------------------
`include "cic_charge_deposit_defines.svh"

module ccd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  ccd_pkg::t_sts i_sts,
    output ccd_pkg::t_cmd o_cmd
);

    typedef enum logic [13:0] {
        S_CLEAR = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_GX    = 14'b00000000000100,
        S_GY    = 14'b00000000001000,
        S_GRND  = 14'b00000000010000,
        S_WGT   = 14'b00000000100000,
        S_MULC  = 14'b00000001000000,
        S_ACC   = 14'b00000010000000,
        S_RADDR = 14'b00000100000000,
        S_RABS  = 14'b00001000000000,
        S_RLO   = 14'b00010000000000,
        S_RHI   = 14'b00100000000000,
        S_RFIN  = 14'b01000000000000,
        S_FIN   = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_ov, n_ov;
    logic   slot_free;

    assign slot_free  = !r_ov || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_GX;
                end
            end
            S_GX: begin
                if (i_sts.is_read) begin
                    n_state = S_RADDR;
                end else begin
                    o_cmd.mul_x = 1'b1;
                    n_state = S_GY;
                end
            end
            S_GY: begin
                o_cmd.mul_y = 1'b1;
                n_state = S_GRND;
            end
            S_GRND: begin
                o_cmd.rnd_y = 1'b1;
                n_state = S_WGT;
            end
            S_WGT: begin
                o_cmd.wgt = 1'b1;
                n_state = S_MULC;
            end
            S_MULC: begin
                o_cmd.mul_c = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = i_sts.last_corner ? S_FIN : S_WGT;
            end
            S_RADDR: begin
                o_cmd.rd_addr = 1'b1;
                n_state = i_sts.rd_inb ? S_RABS : S_FIN;
            end
            S_RABS: begin
                o_cmd.rd_abs = 1'b1;
                n_state = S_RLO;
            end
            S_RLO: begin
                o_cmd.rd_lo = 1'b1;
                n_state = S_RHI;
            end
            S_RHI: begin
                o_cmd.rd_hi = 1'b1;
                n_state = S_RFIN;
            end
            S_RFIN: begin
                o_cmd.rd_fin = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // output slot occupancy
    always_comb begin
        n_ov = r_ov;
        if (o_cmd.load_out) begin
            n_ov = 1'b1;
        end else if (i_out_ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    assign o_out_valid = r_ov;

    // checks
    `CCD_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state != S_IDLE)
    `CCD_ASSERT_NOW(a_load_needs_slot, i_clk, i_rst_n, o_cmd.load_out, !r_ov || i_out_ready)
    `CCD_ASSERT_NOW(a_no_accept_in_clear, i_clk, i_rst_n, r_state == S_CLEAR, !o_in_ready)
    `CCD_ASSERT_NEXT(a_last_corner_done, i_clk, i_rst_n, r_state == S_ACC && i_sts.last_corner, r_state == S_FIN)

endmodule

### hdl/cic_charge_deposit.sv
// ----------------------------------------------------------------------------
// cic_charge_deposit
// two-dimensional cloud-in-cell charge deposition onto an accumulator grid
// ----------------------------------------------------------------------------
// Input channel (valid/ready): a deposit transaction adds a particle's charge
// bilinearly to four grid cells; a read transaction returns one cell's sum
// scaled by the inverse cell area, saturated, and clears that cell.
// Output channel (valid/ready): one result per input transaction, in order.
// Configuration channel: five registers, always ready; the user writes them
// only when idle, the block itself does not enforce it. After reset the grid
// is cleared one cell a cycle over all GRID_X*GRID_Y cells, during which no
// input transaction is taken (configuration still is). One transaction at
// a time: a deposit scales x and y on the shared multiplier, then visits
// four corners, each through weight, charge multiply and accumulate states.
// The result sits in an output register: the next input transaction is
// taken while it waits; a stalled receiver holds the block only once a
// second result is ready.
// ----------------------------------------------------------------------------
module cic_charge_deposit #(
    parameter int GRID_X = 64,
    parameter int GRID_Y = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ccd_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ccd_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ccd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    ccd_pkg::t_cmd cmd;
    ccd_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    // sequencer
    ccd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath and grid
    ccd_dp #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_data  (o_out_data)
    );

endmodule

### sim/cic_charge_deposit_tb.sv
// ----------------------------------------------------------------------------
// cic_charge_deposit_tb
// self-checking bench: deposits and reads against a bit-exact grid predictor
// ----------------------------------------------------------------------------
// A scoreboard class holds its own copy of the registers and the 64x64 charge
// grid, works out each result when an input transaction is accepted and
// compares results in order. Phases change the registers while the block is
// idle, covering unit, wide, zero and extreme spacings and offsets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cic_charge_deposit_tb;

    localparam int NX = 64;
    localparam int NY = 64;
    localparam int WATCHDOG_MAX = 20000;

    class deposit_scoreboard;
        logic signed [31:0] org_x, org_y;
        logic [31:0] inv_x, inv_y, inv_area;
        logic [63:0] grid [NX*NY];
        ccd_pkg::t_out expected_q[$];
        int mismatches;

        function void init();
            org_x = 0; org_y = 0;
            inv_x = ccd_pkg::ONE_Q16; inv_y = ccd_pkg::ONE_Q16;
            inv_area = ccd_pkg::ONE_Q16;
            foreach (grid[k]) grid[k] = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [ccd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
            case (idx)
                ccd_pkg::CFG_ORIGIN_X:      org_x = v;
                ccd_pkg::CFG_ORIGIN_Y:      org_y = v;
                ccd_pkg::CFG_INV_SPACING_X: inv_x = v;
                ccd_pkg::CFG_INV_SPACING_Y: inv_y = v;
                ccd_pkg::CFG_INV_CELL_AREA: inv_area = v;
                default: ;
            endcase
        endfunction

        // (pos - org) * inv, floored to Q.16
        function logic signed [63:0] grid_coord(logic signed [31:0] p,
                                                logic signed [31:0] o, logic [31:0] inv);
            logic signed [33:0] d;
            logic signed [67:0] prod;
            d = 34'(p) - 34'(o);
            prod = 68'(d) * $signed({36'd0, inv});
            return 64'(prod >>> 16);
        endfunction

        function void note_input(ccd_pkg::t_in it);
            ccd_pkg::t_out r;
            logic signed [63:0] gx, gy, ix, iy, cx, cy;
            logic [16:0] wx[2], wy[2];
            logic [33:0] w;
            logic signed [67:0] c;
            logic [63:0] v;
            logic [127:0] full;
            logic signed [127:0] sr;
            r = '0;
            if (it.cmd == ccd_pkg::CMD_DEPOSIT) begin
                gx = grid_coord(it.pos_x, org_x, inv_x);
                gy = grid_coord(it.pos_y, org_y, inv_y);
                ix = gx >>> 16; iy = gy >>> 16;
                wx[1] = {1'b0, gx[15:0]}; wx[0] = 17'h10000 - wx[1];
                wy[1] = {1'b0, gy[15:0]}; wy[0] = 17'h10000 - wy[1];
                for (int b = 0; b < 2; b++)
                    for (int a = 0; a < 2; a++) begin
                        w = wx[a] * wy[b];
                        cx = ix + a; cy = iy + b;
                        if (cx < 0 || cx >= NX || cy < 0 || cy >= NY) begin
                            if (w != 0) r.out_of_range = 1'b1;
                        end else begin
                            c = 68'(it.charge) * $signed({34'd0, w});
                            grid[cy*NX + cx] += 64'(c >>> 16);
                        end
                    end
            end else begin
                v = grid[int'(it.cell_y)*NX + int'(it.cell_x)];
                grid[int'(it.cell_y)*NX + int'(it.cell_x)] = '0;
                // exact product, floored, then saturated
                sr = (128'($signed(v)) * $signed({96'd0, inv_area})) >>> 16;
                full = sr;
                if (sr > 128'sh7FFF_FFFF_FFFF_FFFF) r.density = 64'h7FFF_FFFF_FFFF_FFFF;
                else if (sr < -128'sh8000_0000_0000_0000)
                    r.density = 64'h8000_0000_0000_0000;
                else r.density = full[63:0];
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(ccd_pkg::t_out got);
            ccd_pkg::t_out e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            e = expected_q.pop_front();
            if (got.density !== e.density || got.out_of_range !== e.out_of_range) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: density exp %h got %h, oor exp %b got %b",
                             e.density, got.density, e.out_of_range, got.out_of_range);
            end
        endfunction
    endclass

    logic i_clk = 1'b0, i_rst_n = 1'b0;
    logic i_in_valid = 1'b0, o_in_ready;
    ccd_pkg::t_in i_in_data = '0;
    logic o_out_valid, i_out_ready = 1'b0;
    ccd_pkg::t_out o_out_data;
    logic i_cfg_valid = 1'b0, o_cfg_ready;
    logic [ccd_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    deposit_scoreboard sb;
    int idle_cycles = 0;
    bit calm_sink = 1'b0;
    bit calm_source = 1'b0;

    cic_charge_deposit uut (.*);

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver side: random stalls, results checked on each transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
        i_out_ready <= calm_sink ? 1'b1 : ($urandom_range(99) >= 13);
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_MAX) begin
            $display("cic_charge_deposit_tb: done, errors");
            $finish;
        end
    end

    task automatic write_cfg(logic [ccd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
        i_cfg_valid <= 1'b1; i_cfg_index <= idx; i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, v);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send(ccd_pkg::t_in it);
        while (!calm_source && $urandom_range(99) < 13) @(posedge i_clk);
        i_in_valid <= 1'b1; i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(it);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic ccd_pkg::t_in mk_dep(logic [31:0] px, logic [31:0] py, logic [31:0] q);
        ccd_pkg::t_in it;
        it = '0; it.cmd = ccd_pkg::CMD_DEPOSIT; it.pos_x = px; it.pos_y = py; it.charge = q;
        it.cell_x = 6'($urandom); it.cell_y = 6'($urandom);
        return it;
    endfunction

    function automatic ccd_pkg::t_in mk_rd(logic [5:0] x, logic [5:0] y);
        ccd_pkg::t_in it;
        it = '0; it.cmd = ccd_pkg::CMD_READ; it.cell_x = x; it.cell_y = y;
        it.pos_x = $urandom; it.pos_y = $urandom; it.charge = $urandom;
        return it;
    endfunction

    // mostly in-grid positions, some fully random
    function automatic ccd_pkg::t_in rand_item();
        logic [31:0] px, py, q;
        if ($urandom_range(99) < 30) return mk_rd(6'($urandom), 6'($urandom));
        if ($urandom_range(99) < 80) begin
            px = sb.org_x + $urandom_range(32'h0050_0000);
            py = sb.org_y + $urandom_range(32'h0050_0000);
        end else begin
            px = $urandom; py = $urandom;
        end
        q = ($urandom_range(9) == 0) ? $urandom : 32'($signed($urandom_range(32'h40000)) - 32'sh20000);
        return mk_dep(px, py, q);
    endfunction

    initial begin
        logic [31:0] cfgs[4][5];
        sb = new();
        sb.init();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, corners, edges, reads in and out of use
        calm_sink = 1'b1;
        send(mk_dep(32'h0000_8000, 32'h0000_4000, 32'h0001_0000));
        send(mk_dep(32'h003F_0000, 32'h003F_0000, 32'h7FFF_FFFF));
        send(mk_dep(32'h003F_8000, 32'h0000_0000, 32'h8000_0000));
        send(mk_dep(32'hFFFF_8000, 32'h0001_0000, 32'h0002_0000));
        send(mk_dep(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
        send(mk_dep(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        send(mk_dep(32'h0001_8000, 32'h0002_8000, 32'h7FFF_FFFF));
        send(mk_dep(32'h0001_8000, 32'h0002_8000, 32'h7FFF_FFFF));
        send(mk_rd(6'd0, 6'd0));
        send(mk_rd(6'd63, 6'd63));
        send(mk_rd(6'd1, 6'd2));
        send(mk_rd(6'd1, 6'd2));
        send(mk_rd(6'd63, 6'd0));
        drain();
        calm_sink = 1'b0;

        cfgs[0] = '{32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF};
        cfgs[1] = '{32'hFFF0_0000, 32'h0010_0000, 32'h0004_0000, 32'h0000_4000, 32'h0000_0001};
        cfgs[2] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
        cfgs[3] = '{32'h0000_1234, 32'hFFFF_8000, 32'h0002_0000, 32'h0000_8000, 32'h0001_0000};

        for (int ph = 0; ph < 4; ph++) begin
            for (int r = 0; r < 5; r++) write_cfg(3'(r), cfgs[ph][r]);
            // one phase with no idling on either side
            calm_source = (ph == 1);
            calm_sink = (ph == 1);
            for (int n = 0; n < 250; n++) begin
                send(rand_item());
                // hold the sender until everything has come back
                if (n == 120) drain();
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("cic_charge_deposit_tb: done, clean");
        else
            $display("cic_charge_deposit_tb: done, errors");
        $finish;
    end

endmodule
